>>> src/mexp_pkg.sv
package mexp_pkg;

    // Fixed width of every payload and configuration field
    localparam int unsigned FIELD_W = 32;

    // Configuration register map
    localparam int unsigned ADDR_W      = 2;
    localparam int unsigned ADDR_LSB    = 2;
    localparam int unsigned REG_MODULUS = 0;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MULT,
        ST_NEXT,
        ST_FINISH
    } state_t;

    // Which modular product the shared multiplier is forming
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_RESULT,
        OP_SQUARE
    } mul_op_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic    load_item;
        logic    mul_start;
        logic    mul_step;
        mul_op_t mul_sel;
        logic    write_res;
        logic    write_base;
        logic    shift_exp;
        logic    out_load;
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_upper_zero;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/modular_exponentiation_top.sv
// Channel    Handshake          Payload
// cfg        psel/penable/...   pwdata -> modulus (every paddr hits), prdata readback
// s_         s_valid/s_ready    s_base_value, s_exponent
// m_         m_valid/m_ready    m_power_mod
//
// One request at a time. The shared shift-and-add modular multiplier forms
// one product at a time: one product reduces the base, then each exponent bit
// costs a decision step, a multiply when the bit is set, and a square (top
// bit: multiply only). Synchronous active-low reset; modulus resets to 1. A
// pending result sits in the output register while the next request runs;
// the finish step waits on it.
module modular_exponentiation_top #(
    parameter int WIDTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]              paddr,
    input  logic [mexp_pkg::FIELD_W-1:0]             pwdata,
    output logic [mexp_pkg::FIELD_W-1:0]             prdata,
    output logic                                     pready,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [mexp_pkg::FIELD_W-1:0]             s_base_value,
    input  logic [mexp_pkg::FIELD_W-1:0]             s_exponent,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [mexp_pkg::FIELD_W-1:0]             m_power_mod
);

    logic [mexp_pkg::FIELD_W-1:0] modulus_reg;
    logic                         cfg_hit;
    mexp_pkg::dp_cmd_t            cmd;
    mexp_pkg::dp_status_t         status;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_hit = (paddr >> mexp_pkg::ADDR_LSB)
                     == mexp_pkg::ADDR_W'(mexp_pkg::REG_MODULUS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= mexp_pkg::FIELD_W'(1);
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            modulus_reg <= pwdata;
        end
    end

    assign prdata = modulus_reg;

    mexp_ctrl #(
        .WIDTH(WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mexp_datapath #(
        .WIDTH(WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .modulus      (modulus_reg),
        .s_base_value (s_base_value),
        .s_exponent   (s_exponent),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_power_mod  (m_power_mod)
    );

endmodule

>>> src/mexp_datapath.sv
module mexp_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [mexp_pkg::FIELD_W-1:0]        modulus,
    input  logic [mexp_pkg::FIELD_W-1:0]        s_base_value,
    input  logic [mexp_pkg::FIELD_W-1:0]        s_exponent,
    input  mexp_pkg::dp_cmd_t                   cmd,
    output mexp_pkg::dp_status_t                status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mexp_pkg::FIELD_W-1:0]        m_power_mod
);

    logic [WIDTH-1:0] mod_w;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] res_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [WIDTH-1:0] x_start;
    logic [WIDTH-1:0] y_start;
    logic [WIDTH+1:0] sum_t;
    logic [WIDTH+1:0] mod_x1;
    logic [WIDTH+1:0] mod_x2;
    logic [WIDTH+1:0] sub_x1;
    logic [WIDTH+1:0] sub_x2;
    logic [mexp_pkg::FIELD_W-1:0] out_reg;
    logic             out_valid_reg;

    assign mod_w = WIDTH'(modulus);

    // Operand selection when a product starts
    always_comb begin
        unique case (cmd.mul_sel)
            mexp_pkg::OP_REDUCE: begin
                x_start = WIDTH'(1);
                y_start = base_reg;
            end
            mexp_pkg::OP_RESULT: begin
                x_start = res_reg;
                y_start = base_reg;
            end
            mexp_pkg::OP_SQUARE: begin
                x_start = base_reg;
                y_start = base_reg;
            end
            default: begin
                x_start = base_reg;
                y_start = base_reg;
            end
        endcase
    end

    // One multiplier bit per cycle: acc = (2*acc + bit*x) mod m.
    // With acc < m and x <= m the sum is below 3m, so at most 2m comes off.
    // A zero modulus stands for 2^WIDTH: the sum just wraps.
    assign sum_t  = {1'b0, acc_reg, 1'b0} + (y_reg[WIDTH-1] ? (WIDTH+2)'(x_reg) : '0);
    assign mod_x1 = (WIDTH+2)'(mod_w);
    assign mod_x2 = {1'b0, mod_w, 1'b0};
    assign sub_x1 = sum_t - mod_x1;
    assign sub_x2 = sum_t - mod_x2;

    always_comb begin
        priority if (mod_w == '0) begin
            acc_next = sum_t[WIDTH-1:0];
        end else if (sum_t >= mod_x2) begin
            acc_next = sub_x2[WIDTH-1:0];
        end else if (sum_t >= mod_x1) begin
            acc_next = sub_x1[WIDTH-1:0];
        end else begin
            acc_next = sum_t[WIDTH-1:0];
        end
    end

    // Multiplier registers
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            acc_reg <= '0;
            x_reg   <= x_start;
            y_reg   <= y_start;
        end else if (cmd.mul_step) begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[WIDTH-2:0], 1'b0};
        end
    end

    // Operand registers: base, exponent, running result
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            base_reg <= WIDTH'(s_base_value);
            exp_reg  <= WIDTH'(s_exponent);
            res_reg  <= WIDTH'(1);
        end else begin
            if (cmd.write_base) begin
                base_reg <= acc_next;
            end
            if (cmd.write_res) begin
                res_reg <= acc_next;
            end
            if (cmd.shift_exp) begin
                exp_reg <= {1'b0, exp_reg[WIDTH-1:1]};
            end
        end
    end

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= mexp_pkg::FIELD_W'(res_reg);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_power_mod = out_reg;

    // Status back to the controller
    assign status.exp_zero       = (exp_reg == '0);
    assign status.exp_lsb        = exp_reg[0];
    assign status.exp_upper_zero = (exp_reg[WIDTH-1:1] == '0);
    assign status.out_free       = !out_valid_reg || m_ready;

`ifndef SYNTH
    // Controller only loads the output stage when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output stage overwritten");

    // A loaded result shows up as valid next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

>>> src/mexp_ctrl.sv
module mexp_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::dp_cmd_t    cmd
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    mexp_pkg::state_t  state_reg, state_next;
    mexp_pkg::mul_op_t op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::ST_IDLE;
            op_reg    <= mexp_pkg::OP_REDUCE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = op_reg;
        s_ready    = 1'b0;

        unique case (state_reg)
            mexp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    op_next       = mexp_pkg::OP_REDUCE;
                    state_next    = mexp_pkg::ST_SETUP;
                end
            end
            mexp_pkg::ST_SETUP: begin
                cmd.mul_start = 1'b1;
                cnt_next      = '0;
                state_next    = mexp_pkg::ST_MULT;
            end
            mexp_pkg::ST_MULT: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    unique case (op_reg)
                        mexp_pkg::OP_REDUCE: begin
                            cmd.write_base = 1'b1;
                            state_next     = mexp_pkg::ST_NEXT;
                        end
                        mexp_pkg::OP_RESULT: begin
                            cmd.write_res = 1'b1;
                            // no higher exponent bits: the square is not needed
                            if (status.exp_upper_zero) begin
                                state_next = mexp_pkg::ST_FINISH;
                            end else begin
                                op_next    = mexp_pkg::OP_SQUARE;
                                state_next = mexp_pkg::ST_SETUP;
                            end
                        end
                        mexp_pkg::OP_SQUARE: begin
                            cmd.write_base = 1'b1;
                            cmd.shift_exp  = 1'b1;
                            state_next     = mexp_pkg::ST_NEXT;
                        end
                        default: begin
                            state_next = mexp_pkg::ST_NEXT;
                        end
                    endcase
                end
            end
            mexp_pkg::ST_NEXT: begin
                priority if (status.exp_zero) begin
                    state_next = mexp_pkg::ST_FINISH;
                end else if (status.exp_lsb) begin
                    op_next    = mexp_pkg::OP_RESULT;
                    state_next = mexp_pkg::ST_SETUP;
                end else begin
                    op_next    = mexp_pkg::OP_SQUARE;
                    state_next = mexp_pkg::ST_SETUP;
                end
            end
            mexp_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // An accepted request always starts with the base reduction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == mexp_pkg::ST_SETUP
                                  && op_reg == mexp_pkg::OP_REDUCE))
        else $error("request did not start reduction");

    // A product runs exactly WIDTH steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mexp_pkg::ST_MULT && cnt_reg == CNT_LAST)
            |=> state_reg != mexp_pkg::ST_MULT)
        else $error("multiplier overran its bit count");

    // A finished result leaves as soon as the output stage is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mexp_pkg::ST_FINISH && status.out_free)
            |=> state_reg == mexp_pkg::ST_IDLE)
        else $error("result held back with free output");
`endif

endmodule

>>> tb/tb_modular_exponentiation_top.sv
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 100;
    localparam int TIMEOUT_NS     = 40_000_000;
    localparam int IDLE_PCT       = 27;
    localparam int MAX_GAP        = 20;
    localparam int PHASES         = 7;
    localparam int PHASE_REQUESTS = 37;
    localparam int CALM_FIRST     = 140;
    localparam int CALM_LAST      = 190;
    localparam int HOLD_AT_RESULT = 75;
    localparam int HOLD_CYCLES    = 5000;
    localparam int DIRECTED_ROWS  = 20;

    localparam logic [mexp_pkg::ADDR_W-1:0] MODULUS_ADDR =
        mexp_pkg::ADDR_W'(mexp_pkg::REG_MODULUS << mexp_pkg::ADDR_LSB);

    // One directed request; power_mod is used only when fixed_result is set
    typedef struct packed {
        logic [mexp_pkg::FIELD_W-1:0] modulus;
        logic [mexp_pkg::FIELD_W-1:0] base_value;
        logic [mexp_pkg::FIELD_W-1:0] exponent;
        logic                         fixed_result;
        logic [mexp_pkg::FIELD_W-1:0] power_mod;
    } vector_t;

    logic                         aclk;
    logic                         aresetn      = 1'b0;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [mexp_pkg::ADDR_W-1:0]  paddr        = '0;
    logic [mexp_pkg::FIELD_W-1:0] pwdata       = '0;
    logic [mexp_pkg::FIELD_W-1:0] prdata;
    logic                         pready;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [mexp_pkg::FIELD_W-1:0] s_base_value = '0;
    logic [mexp_pkg::FIELD_W-1:0] s_exponent   = '0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [mexp_pkg::FIELD_W-1:0] m_power_mod;

    logic [mexp_pkg::FIELD_W-1:0] power_mod_due [$];
    logic [mexp_pkg::FIELD_W-1:0] modulus_now = 32'd1;
    int                           fault_count = 0;
    bit                           calm_send   = 1'b0;

    // Directed requests grouped by modulus; the first group runs on the reset value
    vector_t directed_vectors [DIRECTED_ROWS] = '{
        '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'h0000_0001, 32'h0000_0005, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0005, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0003, 32'h0000_0002, 1'b1, 32'h0000_0009},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'h0000_000D, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{32'h0000_000D, 32'h0000_000D, 32'h0000_0007, 1'b1, 32'h0000_0000},
        '{32'h0000_000D, 32'h0000_0002, 32'h0000_000C, 1'b1, 32'h0000_0001},
        '{32'h0000_000D, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'h8000_0000, 32'h0000_0003, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFA, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFB, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000}
    };

    modular_exponentiation_top #(
        .WIDTH(mexp_pkg::FIELD_W)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base_value(s_base_value),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_power_mod (m_power_mod)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Exact product modulo m; zero modulus wraps at the field width
    function automatic logic [63:0] mul_reduce(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] m);
        if (m == 64'd0) begin
            return (a * b) & 64'h0000_0000_FFFF_FFFF;
        end
        return (a * b) % m;
    endfunction

    // Right-to-left square and multiply; the running result starts unreduced at 1
    function automatic logic [mexp_pkg::FIELD_W-1:0] mod_power(
        input logic [mexp_pkg::FIELD_W-1:0] base_in,
        input logic [mexp_pkg::FIELD_W-1:0] exp_in,
        input logic [mexp_pkg::FIELD_W-1:0] modulus_in);
        logic [63:0]                  m;
        logic [63:0]                  b;
        logic [63:0]                  r;
        logic [mexp_pkg::FIELD_W-1:0] e;
        m = 64'(modulus_in);
        b = 64'(base_in);
        e = exp_in;
        r = 64'd1;
        if (m != 64'd0) begin
            b = b % m;
        end
        for (int i = 0; i < mexp_pkg::FIELD_W && e != '0; i++) begin
            if (e[0]) begin
                r = mul_reduce(r, b, m);
            end
            e = e >> 1;
            b = mul_reduce(b, b, m);
        end
        return r[mexp_pkg::FIELD_W-1:0];
    endfunction

    // Offer one request, holding it until accepted; the expectation is queued on accept
    task automatic offer(input logic [mexp_pkg::FIELD_W-1:0] base_in,
                         input logic [mexp_pkg::FIELD_W-1:0] exp_in,
                         input logic [mexp_pkg::FIELD_W-1:0] power_mod_exp);
        int gap;
        gap = 0;
        if (!calm_send) begin
            while (gap < MAX_GAP && $urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_base_value <= base_in;
        s_exponent   <= exp_in;
        do @(posedge aclk); while (s_ready !== 1'b1);
        power_mod_due.push_back(power_mod_exp);
    endtask

    // Wait for the block to drain, then write the modulus and read it back
    task automatic program_modulus(input logic [mexp_pkg::FIELD_W-1:0] value);
        logic [mexp_pkg::FIELD_W-1:0] readback;
        s_valid <= 1'b0;
        while (power_mod_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        // write: setup then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        modulus_now = value;
        if (readback !== value) begin
            $error("modulus readback: expected %h, actual %h", value, readback);
            fault_count++;
        end
    endtask

    // Result side: check each accepted result, idle at random, one long hold-off
    initial begin
        int                           results_seen;
        bit                           calm_recv;
        logic [mexp_pkg::FIELD_W-1:0] power_mod_exp;
        results_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                if (power_mod_due.size() == 0) begin
                    $error("power_mod: no request outstanding, expected none, actual %h",
                           m_power_mod);
                    fault_count++;
                end else begin
                    power_mod_exp = power_mod_due.pop_front();
                    if (m_power_mod !== power_mod_exp) begin
                        $error("power_mod mismatch: expected %h, actual %h",
                               power_mod_exp, m_power_mod);
                        fault_count++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT_RESULT) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    continue;
                end
            end
            calm_recv = (results_seen >= CALM_FIRST + 10 && results_seen < CALM_LAST + 10);
            m_ready <= calm_recv || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus
    initial begin
        vector_t                      row;
        logic [mexp_pkg::FIELD_W-1:0] base_in;
        logic [mexp_pkg::FIELD_W-1:0] exp_in;
        logic [mexp_pkg::FIELD_W-1:0] next_modulus;
        int                           random_count;
        int                           pick;

        random_count = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: moduli 1 (reset), max, zero (wrap), small prime, 2^31, max prime
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_vectors[i];
            if (row.modulus != modulus_now) begin
                program_modulus(row.modulus);
            end
            offer(row.base_value, row.exponent,
                  row.fixed_result ? row.power_mod
                                   : mod_power(row.base_value, row.exponent, modulus_now));
        end

        // Random phases, each on its own modulus
        for (int phase = 0; phase < PHASES; phase++) begin
            unique case (phase)
                0: next_modulus = 32'hFFFF_FFFF;
                1: next_modulus = $urandom_range(2, 255);
                2: next_modulus = 32'h0000_0000;
                3: next_modulus = $urandom | 32'h8000_0000;
                4: next_modulus = 32'h0000_0001;
                5: next_modulus = $urandom;
                default: next_modulus = $urandom_range(2, 65535);
            endcase
            program_modulus(next_modulus);
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                calm_send = (random_count >= CALM_FIRST && random_count < CALM_LAST);
                pick = $urandom_range(0, 99);
                if (pick < 50)      base_in = $urandom;
                else if (pick < 65) base_in = $urandom_range(0, 15);
                else if (pick < 75) base_in = modulus_now - 32'd1;
                else if (pick < 85) base_in = modulus_now + $urandom_range(0, 3);
                else if (pick < 95) base_in = 32'hFFFF_FFFF;
                else                base_in = 32'h0000_0000;
                // mostly short exponents; full-width ones keep the run bounded but present
                pick = $urandom_range(0, 99);
                if (pick < 5)       exp_in = 32'h0000_0000;
                else if (pick < 25) exp_in = $urandom;
                else if (pick < 28) exp_in = 32'hFFFF_FFFF;
                else if (pick < 30) exp_in = 32'h8000_0000;
                else exp_in = $urandom & ((32'd1 << $urandom_range(1, 10)) - 32'd1);
                offer(base_in, exp_in, mod_power(base_in, exp_in, modulus_now));
                random_count++;
            end
        end
        calm_send = 1'b0;

        // Drain and let the block settle before the verdict
        s_valid <= 1'b0;
        while (power_mod_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
